>>> rtl/core/mlr_pkg.sv
package mlr_pkg;

  localparam int unsigned MaxClassesDef  = 16;
  localparam int unsigned MaxFeaturesDef = 64;

  localparam logic [16:0] OneQ16   = 17'd65536;
  localparam logic [12:0] Log2eQ12 = 13'd5909;
  localparam logic [11:0] Ln2Q12   = 12'd2839;

  localparam logic [0:0] KindLoad    = 1'b0;
  localparam logic [0:0] KindFeature = 1'b1;

  localparam logic [0:0] RegNClasses  = 1'b0;
  localparam logic [0:0] RegNFeatures = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StInit,
    StMac,
    StMax,
    StExp,
    StExpSum,
    StLnNorm,
    StLnSq,
    StEmit
  } mlr_state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic init_clr;   // score <= bias (or zero) for the current class
    logic mac;        // score += floor(w * x / 256)
    logic max_first;  // load running max from current score
    logic max_step;   // update running max
    logic exp_start;  // start exp of current class
    logic exp_bit;    // one fraction bit of exp
    logic exp_acc;    // add finished exp into sum
    logic ln_norm;    // one normalize shift
    logic ln_sq;      // one squaring step
    logic emit;       // put result of current class on the port
  } mlr_cmd_t;

  typedef struct packed {
    logic ln_norm_done;
  } mlr_sts_t;

  // 2^-(2^-(b+1)) in Q.16
  function automatic logic [15:0] half_pow(input logic [2:0] b);
    logic [15:0] r;
    begin
      case (b)
        3'd0:    r = 16'd46341;
        3'd1:    r = 16'd55109;
        3'd2:    r = 16'd60097;
        3'd3:    r = 16'd62757;
        3'd4:    r = 16'd64132;
        3'd5:    r = 16'd64830;
        3'd6:    r = 16'd65181;
        3'd7:    r = 16'd65359;
        default: r = 16'd65535;
      endcase
      return r;
    end
  endfunction

endpackage

>>> rtl/core/multiclass_logreg_predict.sv
// sequence: a load is written to parameter memory when accepted; a feature
// that starts a vector first loads bias (or zero) into every class slot, then,
// if its position is in use, does one mac per class in use; the last feature
// then runs the max search, one exp per class, the normalize shifts and the
// squaring steps, then one emit per class; each result is registered from its
// emit; one item at a time, busy is high until it is done; receiver cannot
// stall; reset: asynchronous active low, clears control and config registers
module multiclass_logreg_predict
  import mlr_pkg::*;
#(
  parameter int unsigned MaxClasses  = MaxClassesDef,
  parameter int unsigned MaxFeatures = MaxFeaturesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               kind_i,
  input  logic [10:0]        index_i,
  input  logic signed [15:0] value_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [6:0]         cfg_data_i,
  output logic               result_valid_o,
  output logic [3:0]         class_index_o,
  output logic signed [15:0] log_prob_o,
  output logic               last_o
);

  localparam int unsigned CW    = $clog2(MaxClasses);
  localparam int unsigned FW    = $clog2(MaxFeatures + 1);
  localparam int unsigned Depth = MaxClasses * (MaxFeatures + 1);
  localparam int unsigned AW    = $clog2(Depth);

  logic [4:0]    ncls_q;
  logic [6:0]    nfeat_q;
  logic [FW-1:0] cnt_q;
  logic          ctl_busy;

  assign cfg_ready_o = 1'b1;
  assign busy        = ctl_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncls_q  <= 5'd2;
      nfeat_q <= 7'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegNClasses:  ncls_q  <= cfg_data_i[4:0];
        RegNFeatures: nfeat_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped counts
  logic [CW:0]   nc;
  logic [FW-1:0] nf;
  always_comb begin
    if (ncls_q < 5'd2) nc = (CW+1)'(2);
    else if (32'(ncls_q) > MaxClasses) nc = (CW+1)'(MaxClasses);
    else nc = (CW+1)'(ncls_q);
    if (nfeat_q == '0) nf = FW'(1);
    else if (32'(nfeat_q) > MaxFeatures) nf = FW'(MaxFeatures);
    else nf = FW'(nfeat_q);
  end

  logic acc, feat, load, vlast, inr;
  assign acc   = start && !ctl_busy;
  assign feat  = acc && (kind_i == KindFeature);
  assign load  = acc && (kind_i == KindLoad) && (32'(index_i) < Depth);
  assign vlast = (cnt_q + 1'b1 >= nf);
  assign inr   = (32'(index_i) < 32'(nf));

  // feature counter of the current vector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (feat) begin
      cnt_q <= vlast ? '0 : cnt_q + 1'b1;
    end
  end

  mlr_cmd_t      cmd;
  mlr_sts_t      sts;
  logic [CW-1:0] cls;
  logic [2:0]    bsel;

  mlr_ctrl #(.MaxClasses(MaxClasses)) u_ctrl (
    .clk_i, .rst_ni,
    .start_feat_i(feat),
    .vec_first_i (cnt_q == '0),
    .vec_last_i  (vlast),
    .in_range_i  (inr),
    .nc_i        (nc),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .cls_o       (cls),
    .bit_o       (bsel),
    .busy_o      (ctl_busy)
  );

  mlr_dp #(.MaxClasses(MaxClasses), .MaxFeatures(MaxFeatures)) u_dp (
    .clk_i, .rst_ni,
    .load_i     (load),
    .load_addr_i(AW'(index_i)),
    .value_i,
    .feat_i     (feat),
    .feat_idx_i (FW'(index_i)),
    .nf_i       (nf),
    .nc_i       (nc),
    .cmd_i      (cmd),
    .cls_i      (cls),
    .bit_i      (bsel),
    .sts_o      (sts),
    .res_valid_o(result_valid_o),
    .res_class_o(class_index_o),
    .res_lp_o   (log_prob_o),
    .res_last_o (last_o)
  );

endmodule

>>> rtl/core/mlr_ctrl.sv
module mlr_ctrl
  import mlr_pkg::*;
#(
  parameter int unsigned MaxClasses = MaxClassesDef,
  localparam int unsigned CW = $clog2(MaxClasses)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_feat_i,  // feature item accepted this cycle
  input  logic          vec_first_i,   // this feature starts a vector
  input  logic          vec_last_i,    // this feature ends the vector
  input  logic          in_range_i,    // feature position is in use
  input  logic [CW:0]   nc_i,
  input  mlr_sts_t      sts_i,
  output mlr_cmd_t      cmd_o,
  output logic [CW-1:0] cls_o,
  output logic [2:0]    bit_o,
  output logic          busy_o
);

  mlr_state_e   state_q, state_d;
  logic [CW:0]  cls_q, cls_d;
  logic [2:0]   bit_q, bit_d;
  logic         last_q, last_d;
  logic         rng_q, rng_d;
  logic [CW:0]  ncl_q, ncl_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cls_q   <= '0;
      bit_q   <= '0;
      last_q  <= 1'b0;
      rng_q   <= 1'b0;
      ncl_q   <= '0;
    end else begin
      state_q <= state_d;
      cls_q   <= cls_d;
      bit_q   <= bit_d;
      last_q  <= last_d;
      rng_q   <= rng_d;
      ncl_q   <= ncl_d;
    end
  end

  assign cls_o = cls_q[CW-1:0];
  assign bit_o = bit_q;

  always_comb begin
    state_d = state_q;
    cls_d   = cls_q;
    bit_d   = bit_q;
    last_d  = last_q;
    rng_d   = rng_q;
    ncl_d   = ncl_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      StIdle: begin
        busy_o = 1'b0;
        if (start_feat_i) begin
          last_d = vec_last_i;
          rng_d  = in_range_i;
          ncl_d  = nc_i;
          cls_d  = '0;
          if (vec_first_i) begin
            state_d = StInit;
          end else if (in_range_i) begin
            state_d = StMac;
          end else if (vec_last_i) begin
            state_d = StMax;
          end
        end
      end
      StInit: begin
        cmd_o.init_clr = 1'b1;
        if (cls_q == CW'(MaxClasses - 1)) begin
          cls_d = '0;
          if (rng_q) begin
            state_d = StMac;
          end else if (last_q) begin
            state_d = StMax;
          end else begin
            state_d = StIdle;
          end
        end else begin
          cls_d = cls_q + 1'b1;
        end
      end
      StMac: begin
        cmd_o.mac = 1'b1;
        if (cls_q + 1'b1 >= ncl_q) begin
          cls_d   = '0;
          state_d = last_q ? StMax : StIdle;
        end else begin
          cls_d = cls_q + 1'b1;
        end
      end
      StMax: begin
        cmd_o.max_first = (cls_q == '0);
        cmd_o.max_step  = (cls_q != '0);
        if (cls_q + 1'b1 >= ncl_q) begin
          cls_d   = '0;
          state_d = StExp;
        end else begin
          cls_d = cls_q + 1'b1;
        end
      end
      StExp: begin
        cmd_o.exp_start = 1'b1;
        bit_d   = '0;
        state_d = StExpSum;
      end
      StExpSum: begin
        cmd_o.exp_bit = 1'b1;
        bit_d = bit_q + 1'b1;
        if (bit_q == 3'd7) begin
          cmd_o.exp_acc = 1'b1;
          if (cls_q + 1'b1 >= ncl_q) begin
            cls_d   = '0;
            state_d = StLnNorm;
          end else begin
            cls_d   = cls_q + 1'b1;
            state_d = StExp;
          end
        end
      end
      StLnNorm: begin
        if (sts_i.ln_norm_done) begin
          bit_d   = '0;
          state_d = StLnSq;
        end else begin
          cmd_o.ln_norm = 1'b1;
        end
      end
      StLnSq: begin
        cmd_o.ln_sq = 1'b1;
        bit_d = bit_q + 1'b1;
        if (bit_q == 3'd7) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        if (cls_q + 1'b1 >= ncl_q) begin
          cls_d   = '0;
          state_d = StIdle;
        end else begin
          cls_d = cls_q + 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> cls_q < ncl_q)
    else $error("emit beyond class count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !cmd_o.mac && !cmd_o.emit)
    else $error("datapath command while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.mac, cmd_o.emit, cmd_o.exp_bit, cmd_o.ln_sq, cmd_o.init_clr}))
    else $error("conflicting commands");

endmodule

>>> rtl/core/mlr_dp.sv
module mlr_dp
  import mlr_pkg::*;
#(
  parameter int unsigned MaxClasses  = MaxClassesDef,
  parameter int unsigned MaxFeatures = MaxFeaturesDef,
  localparam int unsigned CW = $clog2(MaxClasses),
  localparam int unsigned FW = $clog2(MaxFeatures + 1),
  localparam int unsigned Depth = MaxClasses * (MaxFeatures + 1),
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic [AW-1:0]      load_addr_i,
  input  logic signed [15:0] value_i,
  input  logic               feat_i,       // feature item accepted
  input  logic [FW-1:0]      feat_idx_i,
  input  logic [FW-1:0]      nf_i,
  input  logic [CW:0]        nc_i,
  input  mlr_cmd_t           cmd_i,
  input  logic [CW-1:0]      cls_i,
  input  logic [2:0]         bit_i,
  output mlr_sts_t           sts_o,
  output logic               res_valid_o,
  output logic [3:0]         res_class_o,
  output logic signed [15:0] res_lp_o,
  output logic               res_last_o
);

  logic signed [15:0] param_mem [Depth];
  logic signed [31:0] score_q [MaxClasses];
  logic signed [15:0] feat_q;
  logic [FW-1:0]      fidx_q;
  logic [FW-1:0]      nfl_q;
  logic [CW:0]        ncl_q;

  // parameter read address for the class the controller points at
  logic [AW+FW:0] stride_base;
  logic [AW-1:0]  raddr;
  assign stride_base = (AW+FW+1)'(cls_i) * (AW+FW+1)'({1'b0, nfl_q} + 1'b1);
  always_comb begin
    if (cmd_i.init_clr) begin
      raddr = AW'(stride_base);
    end else begin
      raddr = AW'(stride_base + (AW+FW+1)'(fidx_q) + 1'b1);
    end
  end

  // registered read: score update runs in the cycle after its command
  logic signed [15:0] rdata_q;
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      param_mem[load_addr_i] <= value_i;
    end
    rdata_q <= param_mem[raddr];
  end

  logic          init_q, mac_q;
  logic [CW-1:0] wcls_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= 1'b0;
      mac_q  <= 1'b0;
    end else begin
      init_q <= cmd_i.init_clr;
      mac_q  <= cmd_i.mac;
    end
  end

  always_ff @(posedge clk_i) begin
    wcls_q <= cls_i;
  end

  always_ff @(posedge clk_i) begin
    if (feat_i) begin
      feat_q <= value_i;
      fidx_q <= feat_idx_i;
      nfl_q  <= nf_i;
      ncl_q  <= nc_i;
    end
  end

  logic signed [31:0] prod;
  assign prod = rdata_q * feat_q;

  always_ff @(posedge clk_i) begin
    if (init_q) begin
      score_q[wcls_q] <= ((CW+1)'(wcls_q) < ncl_q) ? 32'(rdata_q) : '0;
    end else if (mac_q) begin
      score_q[wcls_q] <= score_q[wcls_q] + (prod >>> 8);
    end
  end

  // max search
  logic signed [31:0] mx_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.max_first) begin
      mx_q <= score_q[cls_i];
    end else if (cmd_i.max_step && score_q[cls_i] > mx_q) begin
      mx_q <= score_q[cls_i];
    end
  end

  // exp of d = score - max, one fraction bit per cycle
  logic [32:0]  negd;
  logic [46:0]  tfull;
  logic [30:0]  t;
  logic [7:0]   f_q;
  logic         zero_q;
  logic [4:0]   k_q;
  logic [16:0]  e_q;
  logic [21:0]  sum_q;
  logic [33:0]  emul;
  assign negd  = 33'(mx_q) - 33'(score_q[cls_i]);
  assign tfull = 47'(negd) * 47'(Log2eQ12);
  assign t     = tfull[46:16];
  assign emul  = 34'(e_q) * 34'(half_pow(bit_i)) + 34'd32768;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_start) begin
      f_q    <= t[7:0];
      zero_q <= (t[30:8] >= 23'd17);
      k_q    <= t[12:8];
      e_q    <= OneQ16;
    end else if (cmd_i.exp_bit) begin
      if (f_q[3'd7 - bit_i]) begin
        e_q <= 17'(emul >> 16);
      end
    end
    if (cmd_i.init_clr) begin
      sum_q <= '0;
    end else if (cmd_i.exp_acc) begin
      if (!zero_q) begin
        if (f_q[0] && bit_i == 3'd7) begin
          sum_q <= sum_q + 22'(17'(emul >> 16) >> k_q);
        end else begin
          sum_q <= sum_q + 22'(e_q >> k_q);
        end
      end
    end
  end

  // ln of the sum: normalize, then repeated squaring
  logic [21:0] m_q;
  logic [4:0]  ex_q;
  logic [7:0]  l_q;
  logic [35:0] sq;
  logic [17:0] sqs;
  assign sq  = 36'(m_q[17:0]) * 36'(m_q[17:0]);
  assign sqs = 18'(sq >> 16);
  assign sts_o.ln_norm_done = (m_q < 22'(2 * 65536));

  always_ff @(posedge clk_i) begin
    if (cmd_i.ln_norm) begin
      m_q  <= m_q >> 1;
      ex_q <= ex_q + 1'b1;
    end else if (cmd_i.ln_sq) begin
      if (sqs >= 18'(2 * 65536)) begin
        m_q <= 22'(sqs >> 1);
        l_q <= {l_q[6:0], 1'b1};
      end else begin
        m_q <= 22'(sqs);
        l_q <= {l_q[6:0], 1'b0};
      end
    end
    if (cmd_i.max_first) begin
      ex_q <= '0;
      l_q  <= '0;
    end
    if (cmd_i.exp_acc && bit_i == 3'd7 && 32'(cls_i) + 1 >= 32'(ncl_q)) begin
      if (!zero_q) begin
        if (f_q[0]) begin
          m_q <= sum_q + 22'(17'(emul >> 16) >> k_q);
        end else begin
          m_q <= sum_q + 22'(e_q >> k_q);
        end
      end else begin
        m_q <= sum_q;
      end
    end
  end

  logic [24:0] lns;
  logic [12:0] v;
  assign v   = {ex_q, l_q};
  assign lns = 25'((26'(v) * 26'(Ln2Q12) + 26'd128) >> 8);

  logic signed [34:0] lp;
  logic signed [34:0] q;
  assign lp = 35'(score_q[cls_i]) - 35'(mx_q) - 35'($signed({1'b0, lns})) + 35'sd8;
  assign q  = lp >>> 4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_class_o <= 4'(cls_i);
      res_last_o  <= ((CW+1)'(cls_i) + 1'b1 == ncl_q);
      if (q < -35'sd32768) begin
        res_lp_o <= -16'sd32768;
      end else if (q > 35'sd0) begin
        res_lp_o <= '0;
      end else begin
        res_lp_o <= 16'(q);
      end
    end
  end

endmodule
